// ===== hw/rtl/fmp_pkg.sv =====
`default_nettype none
package fmp_pkg;

    localparam int DEF_MAX_IN_DIM   = 128;
    localparam int DEF_MAX_OUT_DIM  = 32;
    localparam int DEF_MAX_CHANNELS = 8;
    localparam int DEF_VALUE_BITS   = 32;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int ARG_W       = 17;

    typedef enum logic [1:0] {
        OP_LOAD_ROW = 2'd0,
        OP_LOAD_COL = 2'd1,
        OP_SAMPLE   = 2'd2,
        OP_READ     = 2'd3
    } opcode_t;

    localparam logic [CFG_INDEX_W-1:0] REG_OVERLAP_MODE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IN_HEIGHT     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IN_WIDTH      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_HEIGHT    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_WIDTH     = 3'd5;

    localparam logic [7:0] RST_IN_HEIGHT     = 8'd128;
    localparam logic [7:0] RST_IN_WIDTH      = 8'd128;
    localparam logic [3:0] RST_CHANNEL_COUNT = 4'd8;
    localparam logic [5:0] RST_OUT_HEIGHT    = 6'd32;
    localparam logic [5:0] RST_OUT_WIDTH     = 6'd32;

endpackage
`default_nettype wire

// ===== hw/rtl/fmp_ram.sv =====
`default_nettype none
module fmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fractional_max_pool_argmax.sv =====
// Channel | Signals                                              | Direction
// in      | in_valid/in_ready, opcode, bound_*, sample_*, read_* | into block
// out     | out_valid/out_ready, max_value, arg_index, found     | out of block
// cfg     | cfg_write, cfg_index, cfg_data                       | into block
//
// Boundary loads and out-of-range samples are done when taken. A read passes
// ST_RD_ISSUE and ST_RD_DATA, skipping ST_RD_ISSUE when the cell lies outside
// the configured counts. An in-range sample scans both boundary memories, then
// walks the region grid: a row region with no hit is passed whole, a hit row
// column by column, and each hit cell adds a step for the read-modify-write of
// the cell memory. After reset the cell memory is cleared, one entry a cycle
// (8192 entries at default parameters); no transfer is taken in meanwhile. A
// stalled result holds the next read in ST_RD_DATA, and the input with it.
`default_nettype none
module fractional_max_pool_argmax #(
    parameter int MAX_IN_DIM   = fmp_pkg::DEF_MAX_IN_DIM,
    parameter int MAX_OUT_DIM  = fmp_pkg::DEF_MAX_OUT_DIM,
    parameter int MAX_CHANNELS = fmp_pkg::DEF_MAX_CHANNELS,
    parameter int VALUE_BITS   = fmp_pkg::DEF_VALUE_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [fmp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [fmp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      opcode,
    input  wire logic [5:0]                      bound_slot,
    input  wire logic [7:0]                      bound_pos,
    input  wire logic [6:0]                      sample_row,
    input  wire logic [6:0]                      sample_col,
    input  wire logic [2:0]                      sample_chan,
    input  wire logic signed [VALUE_BITS-1:0]    sample_value,
    input  wire logic [4:0]                      read_row,
    input  wire logic [4:0]                      read_col,
    input  wire logic [2:0]                      read_chan,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [VALUE_BITS-1:0]         max_value,
    output logic [fmp_pkg::ARG_W-1:0]           arg_index,
    output logic                                 found
);
    import fmp_pkg::*;

    localparam int IDX_W  = (MAX_OUT_DIM > 1) ? $clog2(MAX_OUT_DIM) : 1;
    localparam int BAW    = $clog2(MAX_OUT_DIM + 1);
    localparam int CHW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CAW    = 2 * IDX_W + CHW;
    localparam int CDEPTH = 1 << CAW;
    localparam int CELL_W = 1 + ARG_W + VALUE_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_UPD,
        ST_WB,
        ST_RD_ISSUE,
        ST_RD_DATA
    } state_t;

    state_t state_reg;

    logic       overlap_reg;
    logic [7:0] in_height_reg;
    logic [7:0] in_width_reg;
    logic [3:0] chan_count_reg;
    logic [5:0] out_height_reg;
    logic [5:0] out_width_reg;

    logic [6:0]            row_reg;
    logic [6:0]            col_reg;
    logic [2:0]            chan_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [15:0]           prod_reg;
    logic [ARG_W-1:0]      arg_reg;
    logic [BAW-1:0]        r_reg;
    logic [BAW-1:0]        c_reg;
    logic [BAW-1:0]        sa_reg;
    logic [BAW-1:0]        pidx_reg;
    logic                  pend_reg;
    logic [7:0]            prev_row_reg;
    logic [7:0]            prev_col_reg;
    logic [MAX_OUT_DIM-1:0] row_hit_reg;
    logic [MAX_OUT_DIM-1:0] col_hit_reg;
    logic                  rd_ok_reg;
    logic                  clr_reg;
    logic [CAW-1:0]        clr_addr_reg;

    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] max_value_reg;
    logic [ARG_W-1:0]      arg_index_reg;
    logic                  found_reg;

    logic [15:0]    oh16;
    logic [15:0]    ow16;
    logic [BAW-1:0] oh;
    logic [BAW-1:0] ow;
    logic [BAW-1:0] n_max;
    logic           in_xfer;
    opcode_t        op;
    logic           slot_ok;
    logic           sample_ok;
    logic           read_ok;

    logic           bnd_row_we;
    logic           bnd_col_we;
    logic [BAW-1:0] bnd_waddr;
    logic [7:0]     bnd_row_rdata;
    logic [7:0]     bnd_col_rdata;

    logic              cell_we;
    logic [CAW-1:0]    cell_waddr;
    logic [CELL_W-1:0] cell_wdata;
    logic [CAW-1:0]    cell_addr;
    logic [CELL_W-1:0] cell_rdata;
    logic [7:0]        chan8;
    logic              cell_v;
    logic [ARG_W-1:0]  cell_arg;
    logic [VALUE_BITS-1:0] cell_max;
    logic              wb_take;
    logic              r_last;
    logic              c_last;
    logic [BAW-1:0]    hidx;
    logic              row_in;
    logic              col_in;
    logic              out_free;

    assign oh16 = (16'(out_height_reg) > 16'(MAX_OUT_DIM)) ? 16'(MAX_OUT_DIM)
                                                           : 16'(out_height_reg);
    assign ow16 = (16'(out_width_reg) > 16'(MAX_OUT_DIM)) ? 16'(MAX_OUT_DIM)
                                                          : 16'(out_width_reg);
    assign oh    = oh16[BAW-1:0];
    assign ow    = ow16[BAW-1:0];
    assign n_max = (oh > ow) ? oh : ow;

    assign in_ready = (state_reg == ST_IDLE) && !clr_reg;
    assign in_xfer  = in_valid && in_ready;
    assign op       = opcode_t'(opcode);

    assign slot_ok   = 16'(bound_slot) <= 16'(MAX_OUT_DIM);
    assign sample_ok = ({1'b0, sample_row} < in_height_reg)
                    && (16'(sample_row) < 16'(MAX_IN_DIM))
                    && ({1'b0, sample_col} < in_width_reg)
                    && (16'(sample_col) < 16'(MAX_IN_DIM))
                    && ({1'b0, sample_chan} < chan_count_reg)
                    && (16'(sample_chan) < 16'(MAX_CHANNELS));
    assign read_ok   = (16'(read_row) < oh16) && (16'(read_col) < ow16)
                    && ({1'b0, read_chan} < chan_count_reg)
                    && (16'(read_chan) < 16'(MAX_CHANNELS));

    assign bnd_waddr  = BAW'(bound_slot);
    assign bnd_row_we = in_xfer && (op == OP_LOAD_ROW) && slot_ok;
    assign bnd_col_we = in_xfer && (op == OP_LOAD_COL) && slot_ok;

    fmp_ram #(.WIDTH(8), .DEPTH(MAX_OUT_DIM + 1)) u_row_bounds (
        .clk   (clk),
        .we    (bnd_row_we),
        .waddr (bnd_waddr),
        .wdata (bound_pos),
        .raddr (sa_reg),
        .rdata (bnd_row_rdata)
    );

    fmp_ram #(.WIDTH(8), .DEPTH(MAX_OUT_DIM + 1)) u_col_bounds (
        .clk   (clk),
        .we    (bnd_col_we),
        .waddr (bnd_waddr),
        .wdata (bound_pos),
        .raddr (sa_reg),
        .rdata (bnd_col_rdata)
    );

    assign chan8     = 8'(chan_reg);
    assign cell_addr = {r_reg[IDX_W-1:0], c_reg[IDX_W-1:0], chan8[CHW-1:0]};
    assign {cell_v, cell_arg, cell_max} = cell_rdata;
    assign wb_take   = !cell_v || ($signed(val_reg) > $signed(cell_max));
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cell_we    = 1'b0;
        cell_waddr = cell_addr;
        cell_wdata = {1'b0, ARG_W'(0), VALUE_BITS'(0)};
        if (clr_reg)
        begin
            cell_we    = 1'b1;
            cell_waddr = clr_addr_reg;
        end
        else if (state_reg == ST_WB)
        begin
            cell_we    = wb_take;
            cell_wdata = {1'b1, arg_reg, val_reg};
        end
        else if (state_reg == ST_RD_DATA)
        begin
            cell_we = rd_ok_reg && out_free;
        end
    end

    fmp_ram #(.WIDTH(CELL_W), .DEPTH(CDEPTH)) u_cells (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_addr),
        .rdata (cell_rdata)
    );

    assign r_last = BAW'(r_reg + BAW'(1)) == oh;
    assign c_last = BAW'(c_reg + BAW'(1)) == ow;
    assign hidx   = BAW'(pidx_reg - BAW'(1));
    assign row_in = ({1'b0, row_reg} >= prev_row_reg)
                 && (9'(row_reg) < 9'(bnd_row_rdata) + 9'(overlap_reg));
    assign col_in = ({1'b0, col_reg} >= prev_col_reg)
                 && (9'(col_reg) < 9'(bnd_col_rdata) + 9'(overlap_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            overlap_reg    <= 1'b0;
            in_height_reg  <= RST_IN_HEIGHT;
            in_width_reg   <= RST_IN_WIDTH;
            chan_count_reg <= RST_CHANNEL_COUNT;
            out_height_reg <= RST_OUT_HEIGHT;
            out_width_reg  <= RST_OUT_WIDTH;
            pend_reg       <= 1'b0;
            row_hit_reg    <= '0;
            col_hit_reg    <= '0;
            clr_reg        <= 1'b1;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
            r_reg          <= '0;
            c_reg          <= '0;
            sa_reg         <= '0;
            pidx_reg       <= '0;
            rd_ok_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_OVERLAP_MODE:  overlap_reg    <= cfg_data[0];
                    REG_IN_HEIGHT:     in_height_reg  <= cfg_data;
                    REG_IN_WIDTH:      in_width_reg   <= cfg_data;
                    REG_CHANNEL_COUNT: chan_count_reg <= cfg_data[3:0];
                    REG_OUT_HEIGHT:    out_height_reg <= cfg_data[5:0];
                    REG_OUT_WIDTH:     out_width_reg  <= cfg_data[5:0];
                    default:           ;
                endcase
            end

            if (clr_reg)
            begin
                clr_addr_reg <= CAW'(clr_addr_reg + CAW'(1));
                if (clr_addr_reg == {CAW{1'b1}})
                begin
                    clr_reg <= 1'b0;
                end
            end

            if ((state_reg != ST_RD_DATA) && out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            prod_reg <= 16'(16'(row_reg) * 16'(in_width_reg) + 16'(col_reg));
            arg_reg  <= ARG_W'(21'(prod_reg) * 21'(chan_count_reg) + 21'(chan_reg));

            if (pend_reg)
            begin
                prev_row_reg <= bnd_row_rdata;
                prev_col_reg <= bnd_col_rdata;
                if (pidx_reg != '0)
                begin
                    row_hit_reg[hidx[IDX_W-1:0]] <= (hidx < oh) && row_in;
                    col_hit_reg[hidx[IDX_W-1:0]] <= (hidx < ow) && col_in;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        case (op)
                            OP_SAMPLE:
                            begin
                                row_reg     <= sample_row;
                                col_reg     <= sample_col;
                                chan_reg    <= sample_chan;
                                val_reg     <= sample_value;
                                row_hit_reg <= '0;
                                col_hit_reg <= '0;
                                sa_reg      <= '0;
                                r_reg       <= '0;
                                c_reg       <= '0;
                                if (sample_ok)
                                begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                            OP_READ:
                            begin
                                r_reg     <= BAW'(read_row);
                                c_reg     <= BAW'(read_col);
                                chan_reg  <= read_chan;
                                rd_ok_reg <= read_ok;
                                state_reg <= read_ok ? ST_RD_ISSUE : ST_RD_DATA;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    pend_reg <= 1'b1;
                    pidx_reg <= sa_reg;
                    if (sa_reg == n_max)
                    begin
                        state_reg <= ST_SCAN_LAST;
                    end
                    else
                    begin
                        sa_reg <= BAW'(sa_reg + BAW'(1));
                    end
                end
                ST_SCAN_LAST:
                begin
                    pend_reg  <= 1'b0;
                    state_reg <= ((oh == '0) || (ow == '0)) ? ST_IDLE : ST_UPD;
                end
                ST_UPD:
                begin
                    if (!row_hit_reg[r_reg[IDX_W-1:0]])
                    begin
                        c_reg <= '0;
                        if (r_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            r_reg <= BAW'(r_reg + BAW'(1));
                        end
                    end
                    else if (col_hit_reg[c_reg[IDX_W-1:0]])
                    begin
                        state_reg <= ST_WB;
                    end
                    else if (c_last)
                    begin
                        c_reg <= '0;
                        if (r_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            r_reg <= BAW'(r_reg + BAW'(1));
                        end
                    end
                    else
                    begin
                        c_reg <= BAW'(c_reg + BAW'(1));
                    end
                end
                ST_WB:
                begin
                    state_reg <= ST_UPD;
                    if (c_last)
                    begin
                        c_reg <= '0;
                        if (r_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            r_reg <= BAW'(r_reg + BAW'(1));
                        end
                    end
                    else
                    begin
                        c_reg <= BAW'(c_reg + BAW'(1));
                    end
                end
                ST_RD_ISSUE:
                begin
                    state_reg <= ST_RD_DATA;
                end
                ST_RD_DATA:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (rd_ok_reg && cell_v)
                        begin
                            max_value_reg <= cell_max;
                            arg_index_reg <= cell_arg;
                            found_reg     <= 1'b1;
                        end
                        else
                        begin
                            max_value_reg <= {1'b1, {(VALUE_BITS-1){1'b0}}};
                            arg_index_reg <= {ARG_W{1'b1}};
                            found_reg     <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign max_value = $signed(max_value_reg);
    assign arg_index = arg_index_reg;
    assign found     = found_reg;

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !in_ready)
        else $error("transfer taken during cell clearing");

    a_update_has_regions: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |-> ((oh != '0) && (ow != '0)))
        else $error("region walk with no regions");

    a_wb_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB) |-> ($past(state_reg) == ST_UPD) && $stable(r_reg)
                                 && $stable(c_reg))
        else $error("cell write without matching read");

endmodule
`default_nettype wire
